FILE: hw/rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: shared types and constants for the binary to decimal ASCII block
// Holds the transaction payload structs, the BCD sizes and the ASCII codes.
// ----------------------------------------------------------------------------
package b2da_pkg;

	// Operand and BCD sizes.
	localparam int unsigned ValueWidth = 64;
	localparam int unsigned NumDigits  = 20;
	localparam int unsigned BcdWidth   = NumDigits * 4;
	localparam int unsigned BitCntW    = $clog2(ValueWidth);
	localparam int unsigned DigCntW    = $clog2(NumDigits + 1);

	// ASCII codes.
	localparam logic [7:0] AsciiZero  = 8'h30;
	localparam logic [7:0] AsciiNine  = 8'h39;
	localparam logic [7:0] AsciiMinus = 8'h2D;

	// Input transaction payload.
	typedef struct packed {
		logic [ValueWidth-1:0] value;
		logic                  is_signed;
	} operand_t;

	// Output transaction payload.
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} text_t;

endpackage

FILE: hw/rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: 64-bit integer to decimal ASCII text
// Converts one signed or unsigned 64-bit operand into its decimal characters,
// most significant first, with a leading minus sign for negative values.
//
//   Channel   Direction  Payload     Meaning
//   operand   in         operand_t   value and signed flag
//   text      out        text_t      one character and its last flag
//
// An operand runs through double-dabble in the shared step unit, one magnitude
// bit per step, then leading zero digits are dropped and the trim ends, then
// the characters are sent. Dropped digits and digit characters always add up
// to 20, and operand_ready rises at the edge that registers the last character.
// Character delivery stalls while text_ready is low; operand_ready is high
// only in the idle state. Reset clears the sequencer, the datapath registers
// and the output valid.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               operand_valid,
	output logic               operand_ready,
	input  b2da_pkg::operand_t operand,
	output logic               text_valid,
	input  logic               text_ready,
	output b2da_pkg::text_t    text
);
	import b2da_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [ValueWidth-1:0] mag_q;
	logic [BcdWidth-1:0]   bcd_q;
	logic [BitCntW-1:0]    bit_cnt_q;
	logic [DigCntW-1:0]    dig_cnt_q;
	logic                  neg_q;
	logic                  text_valid_q;
	text_t                 text_q;

	logic                  neg_in;
	logic [ValueWidth-1:0] mag_in;
	logic [BcdWidth-1:0]   bcd_next;
	logic                  slot_free;
	logic                  emit_fire;
	logic [3:0]            top_digit;

	// Sign and magnitude of the incoming operand.
	assign neg_in = operand.is_signed & operand.value[ValueWidth-1];
	assign mag_in = neg_in ? (~operand.value + {{(ValueWidth-1){1'b0}}, 1'b1})
		: operand.value;

	// Shared double-dabble step.
	b2da_dabble_step u_step (
		.bcd      (bcd_q),
		.bit_in   (mag_q[ValueWidth-1]),
		.bcd_next (bcd_next)
	);

	assign top_digit = bcd_q[BcdWidth-1 -: 4];
	assign slot_free = !text_valid_q || text_ready;

	// A character is loaded into the output register this cycle.
	assign emit_fire = ((state_q == ST_SIGN) || (state_q == ST_EMIT)) && slot_free;

	// Sequencer, datapath registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			text_valid_q <= 1'b0;
			bit_cnt_q    <= '0;
			dig_cnt_q    <= '0;
			neg_q        <= 1'b0;
			mag_q        <= '0;
			bcd_q        <= '0;
			text_q       <= '0;
		end else begin
			if (emit_fire) begin
				text_valid_q <= 1'b1;
			end else if (text_valid_q && text_ready) begin
				text_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (operand_valid) begin
						mag_q     <= mag_in;
						neg_q     <= neg_in;
						bcd_q     <= '0;
						bit_cnt_q <= '0;
						dig_cnt_q <= DigCntW'(NumDigits);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q     <= bcd_next;
					mag_q     <= {mag_q[ValueWidth-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == BitCntW'(ValueWidth - 1)) begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					// Drop leading zero digits, keeping at least one.
					if (top_digit == 4'd0 && dig_cnt_q != DigCntW'(1)) begin
						bcd_q     <= {bcd_q[BcdWidth-5:0], 4'd0};
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end else if (neg_q) begin
						state_q <= ST_SIGN;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						text_q.character <= AsciiMinus;
						text_q.last      <= 1'b0;
						state_q          <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						text_q.character <= AsciiZero + {4'd0, top_digit};
						text_q.last      <= (dig_cnt_q == DigCntW'(1));
						bcd_q            <= {bcd_q[BcdWidth-5:0], 4'd0};
						dig_cnt_q        <= dig_cnt_q - 1'b1;
						if (dig_cnt_q == DigCntW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign operand_ready = (state_q == ST_IDLE);
	assign text_valid    = text_valid_q;
	assign text          = text_q;

endmodule

FILE: hw/rtl/b2da_dabble_step.sv
// ----------------------------------------------------------------------------
// b2da_dabble_step: one double-dabble step
// Adds three to every BCD digit of five or more, then shifts the BCD word
// left by one bit, taking the next binary bit into the low end.
// ----------------------------------------------------------------------------
module b2da_dabble_step (
	input  logic [b2da_pkg::BcdWidth-1:0] bcd,
	input  logic                          bit_in,
	output logic [b2da_pkg::BcdWidth-1:0] bcd_next
);
	import b2da_pkg::*;

	logic [BcdWidth-1:0] adjusted;

	// Correct each digit on its own so the following shift stays decimal.
	always_comb begin
		for (int i = 0; i < NumDigits; i++) begin
			if (bcd[i*4 +: 4] >= 4'd5) begin
				adjusted[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
			end else begin
				adjusted[i*4 +: 4] = bcd[i*4 +: 4];
			end
		end
	end

	// Shift in the next magnitude bit.
	assign bcd_next = {adjusted[BcdWidth-2:0], bit_in};

endmodule

FILE: hw/rtl/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker: port-level checks for binary_to_decimal_ascii
// Watches both channels and flags protocol or content slips.
// ----------------------------------------------------------------------------
module b2da_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               operand_valid,
	input logic               operand_ready,
	input b2da_pkg::operand_t operand,
	input logic               text_valid,
	input logic               text_ready,
	input b2da_pkg::text_t    text
);
	import b2da_pkg::*;

	// A waiting operand holds its value until the transaction completes.
	a_operand_hold: assert property (@(posedge clk) disable iff (!arst_n)
		operand_valid && !operand_ready |=> operand_valid && $stable(operand))
		else $error("operand changed or dropped while stalled");

	// A waiting character holds its value until the transaction completes.
	a_text_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> text_valid && $stable(text))
		else $error("text changed or dropped while stalled");

	// Only one operand is in work at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		operand_valid && operand_ready |=> !operand_ready)
		else $error("operand_ready high right after an accepted operand");

	// Every character is a minus sign or a decimal digit.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> (text.character == AsciiMinus) ||
			((text.character >= AsciiZero) && (text.character <= AsciiNine)))
		else $error("character is neither a digit nor a minus sign");

	// A minus sign always has digits after it.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && (text.character == AsciiMinus) |-> !text.last)
		else $error("minus sign flagged as the last character");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.operand_valid (operand_valid),
	.operand_ready (operand_ready),
	.operand       (operand),
	.text_valid    (text_valid),
	.text_ready    (text_ready),
	.text          (text)
);

FILE: test/binary_to_decimal_ascii_test.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_test: self-checking bench for the decimal text block
// Sends signed and unsigned 64-bit operands, predicts the decimal characters
// of each one, and compares every character and its last flag in order.
// Both channels idle at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_test;

	timeunit 1ns;
	timeprecision 1ps;

	import b2da_pkg::*;

	localparam int unsigned ClockHalf   = 4;
	localparam int unsigned ResetCycles = 10;
	localparam int unsigned RandomItems = 260;
	localparam int unsigned HoldCycles  = 400;
	localparam int unsigned DrainCycles = 120;
	localparam int unsigned CycleLimit  = 400000;

	// Scoreboard: predicts the character run of each operand and checks results.
	class text_scoreboard;
		text_t       expected_text[$];
		int unsigned errors;
		int unsigned operands;
		int unsigned negatives;
		int unsigned longest_runs;
		int unsigned characters;

		function new();
			errors       = 0;
			operands     = 0;
			negatives    = 0;
			longest_runs = 0;
			characters   = 0;
		endfunction

		// Work out the decimal text of one accepted operand.
		function void note_operand(operand_t op);
			logic [ValueWidth-1:0] magnitude;
			logic [7:0]            run[$];
			logic                  negative;
			text_t                 item;
			negative  = op.is_signed && op.value[ValueWidth-1];
			magnitude = negative ? (~op.value + 64'd1) : op.value;
			// Digits are produced least significant first, so each goes to the front.
			do begin
				run.push_front(AsciiZero + 8'(magnitude % 64'd10));
				magnitude = magnitude / 64'd10;
			end while (magnitude != 64'd0);
			if (negative) begin
				run.push_front(AsciiMinus);
				negatives++;
			end
			if (run.size() == NumDigits) begin
				longest_runs++;
			end
			foreach (run[i]) begin
				item.character = run[i];
				item.last      = (i == run.size() - 1);
				expected_text.push_back(item);
			end
			operands++;
		endfunction

		// Compare one accepted character with the oldest prediction.
		function void check_text(text_t got);
			text_t want;
			characters++;
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected character, expected none, actual %h last %b",
					$time, got.character, got.last);
				errors++;
				return;
			end
			want = expected_text.pop_front();
			if (got.character !== want.character) begin
				$display("%0t: character mismatch, expected %h, actual %h",
					$time, want.character, got.character);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last flag mismatch, expected %b, actual %b",
					$time, want.last, got.last);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_text.size();
		endfunction
	endclass

	logic     clk           = 1'b0;
	logic     arst_n        = 1'b0;
	logic     operand_valid = 1'b0;
	logic     operand_ready;
	operand_t operand       = '0;
	logic     text_valid;
	logic     text_ready    = 1'b0;
	text_t    text;

	text_scoreboard sb = new();
	bit             idle_enabled    = 1'b1;
	bit             hold_off_request = 1'b0;
	int unsigned    cycle_count     = 0;

	binary_to_decimal_ascii dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand_valid (operand_valid),
		.operand_ready (operand_ready),
		.operand       (operand),
		.text_valid    (text_valid),
		.text_ready    (text_ready),
		.text          (text)
	);

	// Free-running clock.
	always #(ClockHalf) clk = ~clk;

	// Watchdog on the total number of cycles.
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d characters still expected",
			$time, cycle_count, sb.pending());
		$display("status: fail");
		$finish;
	end

	function automatic operand_t make_operand(logic [ValueWidth-1:0] v, logic s);
		operand_t op;
		op.value     = v;
		op.is_signed = s;
		return op;
	endfunction

	// Random operand: mixes short values, full-width values, small negatives
	// and values near a power of ten so that every run length shows up.
	function automatic operand_t random_operand();
		logic [ValueWidth-1:0] v;
		logic [ValueWidth-1:0] ten_power;
		int unsigned           len;
		int unsigned           kind;
		v    = {$urandom, $urandom};
		len  = $urandom_range(0, 64);
		kind = $urandom_range(0, 3);
		if (len < 64) begin
			v = v & ((64'd1 << len) - 64'd1);
		end
		case (kind)
			0: begin
			end
			1: begin
				v = {$urandom, $urandom};
			end
			2: begin
				v = ~v + 64'd1;
			end
			default: begin
				ten_power = 64'd1;
				repeat ($urandom_range(0, 19)) ten_power = ten_power * 64'd10;
				v = ten_power + 64'($urandom_range(0, 2)) - 64'd1;
			end
		endcase
		return make_operand(v, 1'($urandom));
	endfunction

	// Offer one operand and wait for its transaction. Valid stays high when
	// there is no gap, so it is never lowered and raised within one step.
	task automatic send_operand(operand_t op);
		int unsigned gap;
		gap = idle_enabled ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			operand_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operand       <= op;
		operand_valid <= 1'b1;
		do @(posedge clk); while (!operand_ready);
		sb.note_operand(op);
	endtask

	task automatic wait_for_drain();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Receiver: random stalls before each character, plus one long hold-off.
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_request) begin
				stall            = HoldCycles;
				hold_off_request = 1'b0;
			end else begin
				stall = idle_enabled ? $urandom_range(0, 4) : 0;
			end
			if (stall > 0) begin
				text_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			text_ready <= 1'b1;
			do @(posedge clk); while (!text_valid);
			sb.check_text(text);
		end
	end

	// Reset, directed operands, random operands, drain and verdict.
	initial begin
		operand_t directed[$];
		directed.push_back(make_operand(64'd0, 1'b0));
		directed.push_back(make_operand(64'd0, 1'b1));
		directed.push_back(make_operand(64'd1, 1'b0));
		directed.push_back(make_operand(64'd9, 1'b1));
		directed.push_back(make_operand(64'd10, 1'b0));
		directed.push_back(make_operand(64'd99, 1'b1));
		directed.push_back(make_operand(64'd100, 1'b0));
		// Largest unsigned value and the same bits read as minus one.
		directed.push_back(make_operand(64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
		directed.push_back(make_operand(64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
		// Most negative signed value, and the same bits read as unsigned.
		directed.push_back(make_operand(64'h8000_0000_0000_0000, 1'b1));
		directed.push_back(make_operand(64'h8000_0000_0000_0000, 1'b0));
		directed.push_back(make_operand(64'h7FFF_FFFF_FFFF_FFFF, 1'b1));
		directed.push_back(make_operand(64'h7FFF_FFFF_FFFF_FFFF, 1'b0));
		directed.push_back(make_operand(64'h8000_0000_0000_0001, 1'b1));
		directed.push_back(make_operand(-64'sd10, 1'b1));
		directed.push_back(make_operand(64'd10000000000000000000, 1'b0));
		directed.push_back(make_operand(64'd9999999999999999999, 1'b0));
		directed.push_back(make_operand(64'd1000000000, 1'b1));
		directed.push_back(make_operand(64'h5555_5555_5555_5555, 1'b1));
		directed.push_back(make_operand(64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
		directed.push_back(make_operand(64'hAAAA_AAAA_AAAA_AAAA, 1'b0));

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_operand(directed[i]);
		end

		// Pause the sender until every predicted character has come back.
		operand_valid <= 1'b0;
		wait_for_drain();
		@(posedge clk);

		for (int unsigned n = 0; n < RandomItems; n++) begin
			// Second quarter runs with no idling; third starts with a long hold-off.
			if (n == RandomItems / 4) begin
				idle_enabled = 1'b0;
			end
			if (n == RandomItems / 2) begin
				idle_enabled     = 1'b1;
				hold_off_request = 1'b1;
			end
			send_operand(random_operand());
		end
		operand_valid <= 1'b0;

		wait_for_drain();
		repeat (DrainCycles) @(posedge clk);

		$display("Run covered %0d operands (%0d negative, %0d of full 20-character length),",
			sb.operands, sb.negatives, sb.longest_runs);
		$display("%0d characters checked, %0d errors.", sb.characters, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
